>>> rtl/core/csfr_pkg.sv
// Shared types and constants for the chassis status frame receiver.
// Frame geometry, result status codes, register indexes and the result record.
// No dependencies.
`default_nettype none

package csfr_pkg;

	localparam int unsigned FRAME_LEN = 24;
	localparam int unsigned POS_W     = $clog2(FRAME_LEN);
	localparam int unsigned STORE_N   = FRAME_LEN - 1;
	localparam int unsigned CSUM_POS  = FRAME_LEN - 2;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TAIL   = CFG_IDX_W'(1);

	localparam logic [7:0] HEADER_RST = 8'h7B;
	localparam logic [7:0] TAIL_RST   = 8'h7D;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_TAIL = 2'd1,
		ST_CSUM = 2'd2
	} frame_status_t;

	typedef logic [STORE_N-1:0][7:0] store_t;

	typedef struct packed {
		frame_status_t      status;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic signed [15:0] vel_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] supply_mv;
	} result_t;

	function automatic logic [7:0] byte_at(input store_t st, input logic [7:0] last_b,
			input int unsigned idx);
		logic [POS_W-1:0] i;
		i = POS_W'(idx);
		if (idx < STORE_N)
			return st[i];
		else if (idx == STORE_N)
			return last_b;
		else
			return 8'h00;
	endfunction

	function automatic logic signed [15:0] be16(input store_t st, input logic [7:0] last_b,
			input int unsigned hi);
		return $signed({byte_at(st, last_b, hi), byte_at(st, last_b, hi + 1)});
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/csfr_deframer.sv
// Frame position counter, running XOR and byte capture; builds the result record
// on the last byte of a frame. Depends on csfr_pkg.
`default_nettype none

module csfr_deframer (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic [7:0]        rx_byte,
	input  wire logic [7:0]        header_byte,
	input  wire logic [7:0]        tail_byte,
	output      logic              at_last,
	output      logic              res_valid,
	output      csfr_pkg::result_t res
);
	import csfr_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;
	store_t           store_q;
	logic             idle;
	logic             start;
	logic [7:0]       xor_base;
	logic [7:0]       xor_in;
	frame_status_t    status;

	assign idle    = (pos_q == '0);
	assign at_last = (pos_q == POS_W'(FRAME_LEN - 1));
	assign start   = idle && (rx_byte == header_byte);

	assign xor_base = idle ? 8'h00 : xor_q;
	assign xor_in   = (32'(pos_q) + 2 < FRAME_LEN) ? rx_byte : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
		end else if (take && (start || !idle)) begin
			xor_q <= at_last ? 8'h00 : (xor_base ^ xor_in);
			pos_q <= at_last ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take && (start || !idle) && !at_last)
			store_q[pos_q] <= rx_byte;
	end

	always_comb begin
		if (rx_byte != tail_byte)
			status = ST_TAIL;
		else if (byte_at(store_q, rx_byte, CSUM_POS) != xor_q)
			status = ST_CSUM;
		else
			status = ST_OK;
	end

	always_comb begin
		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.vel_x     = be16(store_q, rx_byte, 2);
			res.vel_y     = be16(store_q, rx_byte, 4);
			res.vel_z     = be16(store_q, rx_byte, 6);
			res.accel_x   = be16(store_q, rx_byte, 8);
			res.accel_y   = be16(store_q, rx_byte, 10);
			res.accel_z   = be16(store_q, rx_byte, 12);
			res.supply_mv = be16(store_q, rx_byte, 20);
		end
	end

	assign res_valid = take && at_last && !idle;

endmodule

`default_nettype wire

>>> rtl/core/csfr_out_reg.sv
// Result register with valid/ready hand-off to the consumer.
// Depends on csfr_pkg.
`default_nettype none

module csfr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire csfr_pkg::result_t res_in,
	input  wire logic              out_ready,
	output      logic              out_valid,
	output      csfr_pkg::result_t res_out
);
	import csfr_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res_in;
	end

	assign out_valid = valid_q;
	assign res_out   = res_q;

endmodule

`default_nettype wire

>>> rtl/core/chassis_status_frame_receiver.sv
// Top level of the chassis status frame receiver: configuration registers,
// deframer and result register. Depends on csfr_pkg, csfr_deframer, csfr_out_reg.
`default_nettype none

// Takes one received byte per cycle and assembles fixed 24-byte frames that open on the
// header byte; the position then runs to the end of the frame with no resynchronisation.
// The 24th byte of a frame yields one result in the next cycle: status (ok, bad tail,
// or XOR of bytes 0..21 not equal to byte 22, tail checked first) and the big-endian
// signed fields, all zero on a bad frame. Bytes outside a frame are dropped silently.
// Input rate is one byte per cycle; the only stall is on the last byte of a frame while
// the previous result is still held in the single result register.
// Write header_byte and tail_byte only while no frame is in progress.
module chassis_status_frame_receiver (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [csfr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [csfr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                               in_valid,
	output      logic                               in_ready,
	input  wire logic [7:0]                         rx_byte,
	output      logic                               out_valid,
	input  wire logic                               out_ready,
	output      logic [1:0]                         frame_status,
	output      logic signed [15:0]                 vel_x,
	output      logic signed [15:0]                 vel_y,
	output      logic signed [15:0]                 vel_z,
	output      logic signed [15:0]                 accel_x,
	output      logic signed [15:0]                 accel_y,
	output      logic signed [15:0]                 accel_z,
	output      logic signed [15:0]                 supply_mv
);
	import csfr_pkg::*;

	logic [7:0] header_q;
	logic [7:0] tail_q;
	logic       take;
	logic       at_last;
	logic       res_valid;
	result_t    res;
	result_t    res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RST;
			tail_q   <= TAIL_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HEADER: header_q <= cfg_wdata[7:0];
				REG_TAIL:   tail_q   <= cfg_wdata[7:0];
				default:    ;
			endcase
		end
	end

	assign in_ready = !(at_last && out_valid && !out_ready);
	assign take     = in_valid && in_ready;

	csfr_deframer u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.rx_byte    (rx_byte),
		.header_byte(header_q),
		.tail_byte  (tail_q),
		.at_last    (at_last),
		.res_valid  (res_valid),
		.res        (res)
	);

	csfr_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (res_valid),
		.res_in   (res),
		.out_ready(out_ready),
		.out_valid(out_valid),
		.res_out  (res_out)
	);

	assign frame_status = res_out.status;
	assign vel_x        = res_out.vel_x;
	assign vel_y        = res_out.vel_y;
	assign vel_z        = res_out.vel_z;
	assign accel_x      = res_out.accel_x;
	assign accel_y      = res_out.accel_y;
	assign accel_z      = res_out.accel_z;
	assign supply_mv    = res_out.supply_mv;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid || out_ready))
		else $error("result register overwritten while held");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(take && at_last))
		else $error("result raised without a completed frame");

	a_bad_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && res_out.status != ST_OK) |->
		(vel_x == '0 && vel_y == '0 && vel_z == '0 && accel_x == '0 &&
		 accel_y == '0 && accel_z == '0 && supply_mv == '0))
		else $error("bad frame carries non-zero fields");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for chassis_status_frame_receiver: byte stream in, frame results out.
// Holds a byte-level predictor of the deframer and checks every result against it.
// Depends on csfr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
	import csfr_pkg::*;

	typedef enum int {
		FR_GOOD,
		FR_BAD_TAIL,
		FR_BAD_SUM,
		FR_BAD_BOTH
	} frame_kind_t;

	typedef logic [7:0] frame_bytes_t [FRAME_LEN];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_HEADER;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] frame_status;
	logic signed [15:0] vel_x, vel_y, vel_z;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic signed [15:0] supply_mv;

	logic [7:0] rx_backlog [$];
	result_t due_frames [$];

	logic [7:0] hdr_reg = HEADER_RST;
	logic [7:0] tail_reg = TAIL_RST;
	int unsigned fr_pos = 0;
	logic [7:0] fr_xor = 8'h00;
	logic [7:0] fr_bytes [FRAME_LEN];

	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned n_queued = 0;
	int unsigned n_taken = 0;
	int unsigned n_frame_bytes = 0;
	int unsigned n_fail = 0;
	int unsigned n_checked = 0;
	int unsigned n_ok = 0;
	int unsigned n_tail = 0;
	int unsigned n_sum = 0;

	logic [7:0] hdr_plan [4] = '{8'h00, 8'hFF, 8'h00, HEADER_RST};
	logic [7:0] tail_plan [4] = '{8'hFF, 8'h00, 8'h00, TAIL_RST};
	int unsigned src_plan [4] = '{73, 0, 8, 30};
	int unsigned sink_plan [4] = '{0, 73, 8, 30};

	chassis_status_frame_receiver u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_status (frame_status),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.supply_mv    (supply_mv)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic absorb_byte(input logic [7:0] b);
		result_t r;
		if (fr_pos == 0) begin
			if (b != hdr_reg)
				return;
			fr_xor = 8'h00;
		end
		fr_bytes[fr_pos] = b;
		if (fr_pos + 2 < FRAME_LEN)
			fr_xor ^= b;
		fr_pos++;
		if (fr_pos < FRAME_LEN)
			return;
		fr_pos = 0;
		r = '0;
		if (fr_bytes[FRAME_LEN-1] != tail_reg) begin
			r.status = ST_TAIL;
		end else if (fr_bytes[FRAME_LEN-2] != fr_xor) begin
			r.status = ST_CSUM;
		end else begin
			r.status = ST_OK;
			r.vel_x = {fr_bytes[2], fr_bytes[3]};
			r.vel_y = {fr_bytes[4], fr_bytes[5]};
			r.vel_z = {fr_bytes[6], fr_bytes[7]};
			r.accel_x = {fr_bytes[8], fr_bytes[9]};
			r.accel_y = {fr_bytes[10], fr_bytes[11]};
			r.accel_z = {fr_bytes[12], fr_bytes[13]};
			r.supply_mv = {fr_bytes[20], fr_bytes[21]};
		end
		fr_xor = 8'h00;
		due_frames.push_back(r);
	endtask

	// sender: one transfer per handshake, random gaps between bytes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				absorb_byte(rx_byte);
				n_taken++;
			end
			if (!in_valid || in_ready) begin
				if (rx_backlog.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= rx_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic signed [15:0] want,
			input logic signed [15:0] got);
		if (got !== want) begin
			n_fail++;
			if (n_fail <= 10)
				$display("frame %0d %s: expected %0d got %0d", n_checked, name, want, got);
		end
	endtask

	task automatic check_frame();
		result_t want;
		if (due_frames.size() == 0) begin
			n_fail++;
			if (n_fail <= 10)
				$display("frame %0d: result with no frame outstanding", n_checked);
			return;
		end
		want = due_frames.pop_front();
		compare_field("frame_status", want.status, frame_status);
		compare_field("vel_x", want.vel_x, vel_x);
		compare_field("vel_y", want.vel_y, vel_y);
		compare_field("vel_z", want.vel_z, vel_z);
		compare_field("accel_x", want.accel_x, accel_x);
		compare_field("accel_y", want.accel_y, accel_y);
		compare_field("accel_z", want.accel_z, accel_z);
		compare_field("supply_mv", want.supply_mv, supply_mv);
		case (want.status)
			ST_OK: n_ok++;
			ST_TAIL: n_tail++;
			default: n_sum++;
		endcase
		n_checked++;
	endtask

	// receiver: check each transfer, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_frame();
			out_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		rx_backlog.push_back(b);
		n_queued++;
	endtask

	task automatic queue_frame(input frame_kind_t kind, input frame_bytes_t fb,
			input int unsigned len);
		logic [7:0] bcc;
		bcc = 8'h00;
		fb[0] = hdr_reg;
		for (int i = 0; i < FRAME_LEN - 2; i++)
			bcc ^= fb[i];
		fb[FRAME_LEN-2] = bcc;
		fb[FRAME_LEN-1] = tail_reg;
		if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH)
			fb[FRAME_LEN-2] ^= 8'($urandom_range(255, 1));
		if (kind == FR_BAD_TAIL || kind == FR_BAD_BOTH)
			fb[FRAME_LEN-1] ^= 8'($urandom_range(255, 1));
		for (int i = 0; i < len; i++)
			queue_byte(fb[i]);
		n_frame_bytes += len;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (n_taken != n_queued || due_frames.size() != 0);
	endtask

	// finish any partial frame so the deframer is idle before a register write
	task automatic settle();
		wait_drained();
		if (fr_pos != 0) begin
			repeat (FRAME_LEN - fr_pos) queue_byte(8'($urandom));
			wait_drained();
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		if (idx == REG_HEADER)
			hdr_reg = val;
		else
			tail_reg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_traffic(input int unsigned budget);
		frame_bytes_t fb;
		int unsigned start;
		int unsigned pick;
		bit paused;
		start = n_frame_bytes;
		paused = 1'b0;
		while (n_frame_bytes - start < budget) begin
			if (!paused && n_frame_bytes - start >= budget / 2) begin
				paused = 1'b1;
				wait_drained();
			end
			if ($urandom_range(99, 0) < 25)
				repeat ($urandom_range(3, 1)) queue_byte(8'($urandom));
			foreach (fb[i])
				fb[i] = 8'($urandom);
			pick = $urandom_range(99, 0);
			if (pick < 78)
				queue_frame(FR_GOOD, fb, FRAME_LEN);
			else if (pick < 84)
				queue_frame(FR_BAD_TAIL, fb, FRAME_LEN);
			else if (pick < 90)
				queue_frame(FR_BAD_SUM, fb, FRAME_LEN);
			else if (pick < 94)
				queue_frame(FR_BAD_BOTH, fb, FRAME_LEN);
			else
				queue_frame(FR_GOOD, fb, $urandom_range(FRAME_LEN - 1, 1));
		end
	endtask

	initial begin
		frame_bytes_t fb;
		hdr_plan[2] = 8'($urandom);
		tail_plan[2] = 8'($urandom);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// line noise, then frames at the field extremes and every fault
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(TAIL_RST);
		fb = '{default: 8'h00};
		fb[2] = 8'h7F; fb[3] = 8'hFF;
		fb[4] = 8'h80; fb[5] = 8'h00;
		fb[6] = 8'hFF; fb[7] = 8'hFF;
		fb[10] = 8'h00; fb[11] = 8'h01;
		fb[12] = 8'hFF; fb[13] = 8'hFE;
		fb[20] = 8'h80; fb[21] = 8'h00;
		queue_frame(FR_GOOD, fb, FRAME_LEN);
		fb = '{default: 8'hFF};
		queue_frame(FR_GOOD, fb, FRAME_LEN);
		foreach (fb[i])
			fb[i] = 8'($urandom);
		queue_frame(FR_BAD_TAIL, fb, FRAME_LEN);
		queue_frame(FR_BAD_SUM, fb, FRAME_LEN);
		queue_frame(FR_BAD_BOTH, fb, FRAME_LEN);
		random_traffic(345);

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_reg(REG_HEADER, hdr_plan[ph]);
			write_reg(REG_TAIL, tail_plan[ph]);
			src_idle_pct = src_plan[ph];
			sink_stall_pct = sink_plan[ph];
			random_traffic(345);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("sent %0d frame bytes and %0d noise bytes across five header/tail settings",
			n_frame_bytes, n_queued - n_frame_bytes);
		$display("checked %0d frames: %0d ok, %0d bad tail, %0d bad checksum, %0d outstanding",
			n_checked, n_ok, n_tail, n_sum, due_frames.size());
		if (n_fail == 0 && due_frames.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
